/* rtl/core/vrrq_pkg.sv */
// Shared types, constants and helpers of the quadratic variable-rate resampler.
`timescale 1ns / 1ps
`default_nettype none

package vrrq_pkg;

    // Fixed field widths
    localparam int SAMPLE_BITS   = 16;
    localparam int RATIO_BITS    = 21;
    localparam int GAIN_BITS     = 16;
    localparam int PAN_BITS      = 17;

    // Fixed-point formats of the registers
    localparam int RATIO_FRAC    = 16;
    localparam int GAIN_FRAC     = 12;
    localparam int PAN_FRAC      = 16;

    // Default position fraction width
    localparam int FRAC_BITS_DEF = 16;

    // Configuration port
    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = 21;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_STEP_RATIO = 4'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_GAIN       = 4'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PAN_LEFT   = 4'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_STEREO     = 4'd3;

    localparam logic [RATIO_BITS-1:0] STEP_RESET = 21'd65536;
    localparam logic [GAIN_BITS-1:0]  GAIN_RESET = 16'd4096;
    localparam logic [PAN_BITS-1:0]   PAN_RESET  = 17'd32768;
    localparam logic [PAN_BITS-1:0]   PAN_ONE    = 17'h10000;

    // Burst limit per input item
    localparam int MAX_RESULTS = 64;
    localparam int CNT_BITS    = $clog2(MAX_RESULTS);

    // Shared multiplier and datapath widths
    localparam int MUL_BITS  = 32;
    localparam int PROD_BITS = 2 * MUL_BITS;
    localparam int DIFF_BITS = 20;   // 2b and 2c coefficients
    localparam int Y_BITS    = 26;   // interpolated value before gain
    localparam int M_BITS    = 30;   // value after gain

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TT,
        ST_BT,
        ST_CT,
        ST_SUM,
        ST_Y,
        ST_G,
        ST_M,
        ST_PL,
        ST_PR,
        ST_EMIT
    } vrrq_state_t;

    // Clamp a scaled value to the signed sample range
    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
        input logic signed [M_BITS-1:0] x
    );
        logic signed [M_BITS-1:0] hi;
        logic signed [M_BITS-1:0] lo;
        hi = {{(M_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
        lo = {{(M_BITS-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};
        if (x > hi)
        begin
            sat_sample = hi[SAMPLE_BITS-1:0];
        end
        else if (x < lo)
        begin
            sat_sample = lo[SAMPLE_BITS-1:0];
        end
        else
        begin
            sat_sample = x[SAMPLE_BITS-1:0];
        end
    endfunction

endpackage

`default_nettype wire

/* rtl/core/vrrq_if.sv */
// Channel interfaces of the resampler: sample input, result output, configuration writes.
`timescale 1ns / 1ps
`default_nettype none

interface vrrq_in_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [vrrq_pkg::SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface vrrq_out_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [vrrq_pkg::SAMPLE_BITS-1:0] left_out;
    logic signed [vrrq_pkg::SAMPLE_BITS-1:0] right_out;
    logic                                    last;

    modport source (output valid, output left_out, output right_out, output last,
                    input ready);
    modport sink   (input valid, input left_out, input right_out, input last,
                    output ready);
endinterface

interface vrrq_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic [vrrq_pkg::CFG_INDEX_BITS-1:0]   index;
    logic [vrrq_pkg::CFG_DATA_BITS-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/variable_rate_resampler_quadratic_core.sv */
// Top level of the quadratic-interpolation variable-rate resampler.
`timescale 1ns / 1ps
`default_nettype none

// Variable-rate resampler with three-point quadratic interpolation. Each
// sample item shifts a three-entry history and moves the read position back
// by one sample; when the position falls below one half, the block emits a
// burst of one to 64 result items, each interpolated at position + 2, scaled
// by the gain and, in stereo mode, split by the pan. All multiplications go
// through one registered 32x32 signed multiplier driven by a small sequencer.
// An item that causes no result leaves the sequencer idle. For an item that
// causes results, each result passes through the states TT, BT, CT, SUM, Y, G,
// M and, in stereo, PL and PR (four or six passes through the shared multiplier
// plus rounding steps) before EMIT, which holds while the result channel stalls;
// the sample channel is ready only while the sequencer is idle. The output
// register lets the next sample be taken while the last result still waits.
// Configuration writes are always accepted and take effect at once.
module variable_rate_resampler_quadratic_core #(
    parameter int FRAC_BITS = vrrq_pkg::FRAC_BITS_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    vrrq_in_if.sink     samples,
    vrrq_out_if.source  results,
    vrrq_cfg_if.sink    cfg
);

    // Derived widths
    localparam int P     = FRAC_BITS + 8;              // read position
    localparam int TW    = FRAC_BITS + 5;              // interpolation point
    localparam int TTW   = FRAC_BITS + 7;              // squared point
    localparam int INCW  = FRAC_BITS + 5;              // position increment
    localparam int SHW   = vrrq_pkg::RATIO_BITS + FRAC_BITS;
    localparam int ACCW  = FRAC_BITS + 1 + vrrq_pkg::Y_BITS;
    localparam int SB    = vrrq_pkg::SAMPLE_BITS;
    localparam int MB    = vrrq_pkg::MUL_BITS;
    localparam int PB    = vrrq_pkg::PROD_BITS;
    localparam int DB    = vrrq_pkg::DIFF_BITS;
    localparam int YB    = vrrq_pkg::Y_BITS;
    localparam int MMB   = vrrq_pkg::M_BITS;

    // Position constants
    localparam logic signed [P-1:0] POS_ONE   = P'(64'd1 << FRAC_BITS);
    localparam logic signed [P-1:0] POS_HALF  = P'(64'd1 << (FRAC_BITS - 1));
    localparam logic signed [P-1:0] POS_NHALF = -POS_HALF;
    localparam logic signed [P-1:0] POS_MAX   = {1'b0, {(P-1){1'b1}}};
    localparam logic signed [P-1:0] POS_MIN   = {1'b1, {(P-1){1'b0}}};
    localparam logic signed [P:0]   T_TWO     = (P+1)'(64'd1 << (FRAC_BITS + 1));
    localparam logic signed [P:0]   T_MAX     = (P+1)'(64'd1 << (FRAC_BITS + 3));
    localparam logic signed [P:0]   T_MIN     = -T_MAX;

    // Rounding offsets
    localparam logic signed [PB-1:0]   TT_RND  = PB'(64'd1 << (FRAC_BITS - 1));
    localparam logic signed [ACCW-1:0] Y_RND   = ACCW'(64'd1 << FRAC_BITS);
    localparam logic signed [PB-1:0]   M_RND   = PB'(64'd1 << (vrrq_pkg::GAIN_FRAC - 1));
    localparam logic signed [PB-1:0]   PAN_RND = PB'(64'd1 << (vrrq_pkg::PAN_FRAC - 1));

    localparam logic [vrrq_pkg::CNT_BITS-1:0] CNT_LAST =
        vrrq_pkg::CNT_BITS'(vrrq_pkg::MAX_RESULTS - 1);

    // Control state
    vrrq_pkg::vrrq_state_t state_reg, state_next;
    logic signed [P-1:0]   pos_reg;
    logic signed [SB-1:0]  hist_older_reg, hist_old_reg, hist_new_reg;
    logic [vrrq_pkg::CNT_BITS-1:0] cnt_reg;
    logic                  out_valid_reg;

    // Configuration registers
    logic [vrrq_pkg::RATIO_BITS-1:0] step_reg;
    logic [vrrq_pkg::GAIN_BITS-1:0]  gain_reg;
    logic [vrrq_pkg::PAN_BITS-1:0]   pan_reg;
    logic                            stereo_reg;

    // Datapath registers
    logic signed [PB-1:0]   prod_reg;
    logic [TTW-1:0]         tt_reg;
    logic signed [ACCW-1:0] acc_reg;
    logic signed [YB-1:0]   y_reg;
    logic signed [MMB-1:0]  m_reg;
    logic signed [SB-1:0]   pan_l_reg;
    logic signed [SB-1:0]   left_reg, right_reg;
    logic                   last_reg;

    // Combinational signals
    logic                   accept;
    logic                   emit_go;
    logic                   more;
    logic                   samples_ready;
    logic                   mul_en;
    logic signed [MB-1:0]   mul_a, mul_b;
    logic signed [PB-1:0]   mul_p;
    logic signed [P:0]      pos_dec_w, pos_inc_w;
    logic signed [P-1:0]    pos_dec_sat, pos_inc_sat;
    logic [SHW-1:0]         step_sh;
    logic [INCW-1:0]        inc;
    logic signed [P:0]      t_w, t_c;
    logic signed [TW-1:0]   t_val;
    logic signed [DB-1:0]   y0e, y1e, y2e, b2, c2;
    logic signed [PB-1:0]   tt_rnd, m_rnd, s_rnd;
    logic [TTW-1:0]         tt_next;
    logic signed [ACCW-1:0] acc_next;
    logic signed [YB-1:0]   y_next;
    logic signed [MMB-1:0]  m_next, s_val;
    logic [vrrq_pkg::PAN_BITS-1:0] pan_l, pan_r;

    // Handshakes
    assign accept  = samples.valid && samples_ready;
    assign emit_go = (state_reg == vrrq_pkg::ST_EMIT) && (!out_valid_reg || results.ready);
    assign samples.ready = samples_ready;
    assign cfg.ready     = 1'b1;

    // Step back one sample, saturating
    assign pos_dec_w = {pos_reg[P-1], pos_reg} - {POS_ONE[P-1], POS_ONE};
    assign pos_dec_sat = (pos_dec_w[P] != pos_dec_w[P-1])
                       ? (pos_dec_w[P] ? POS_MIN : POS_MAX) : pos_dec_w[P-1:0];

    // Advance by the step ratio rescaled to the position format, saturating
    assign step_sh = {step_reg, {FRAC_BITS{1'b0}}};
    assign inc     = step_sh[SHW-1:vrrq_pkg::RATIO_FRAC];
    assign pos_inc_w = {pos_reg[P-1], pos_reg} + {{(P+1-INCW){1'b0}}, inc};
    assign pos_inc_sat = (pos_inc_w[P] != pos_inc_w[P-1])
                       ? (pos_inc_w[P] ? POS_MIN : POS_MAX) : pos_inc_w[P-1:0];
    assign more = (pos_inc_sat < POS_NHALF) && (cnt_reg != CNT_LAST);

    // Interpolation point, clamped to +/- 8
    assign t_w = {pos_reg[P-1], pos_reg} + T_TWO;
    always_comb
    begin
        if (t_w > T_MAX)
        begin
            t_c = T_MAX;
        end
        else if (t_w < T_MIN)
        begin
            t_c = T_MIN;
        end
        else
        begin
            t_c = t_w;
        end
    end
    assign t_val = t_c[TW-1:0];

    // Quadratic coefficients from the history
    assign y0e = {{(DB-SB){hist_older_reg[SB-1]}}, hist_older_reg};
    assign y1e = {{(DB-SB){hist_old_reg[SB-1]}}, hist_old_reg};
    assign y2e = {{(DB-SB){hist_new_reg[SB-1]}}, hist_new_reg};
    assign b2  = (y1e <<< 2) - (y0e <<< 1) - y0e - y2e;
    assign c2  = y0e - (y1e <<< 1) + y2e;

    // Rounding and narrowing of products
    assign tt_rnd   = prod_reg + TT_RND;
    assign tt_next  = tt_rnd[FRAC_BITS+TTW-1:FRAC_BITS];
    assign acc_next = acc_reg + prod_reg[ACCW-1:0] + Y_RND;
    assign y_next   = {{(YB-SB){hist_older_reg[SB-1]}}, hist_older_reg}
                    + acc_reg[ACCW-1:FRAC_BITS+1];
    assign m_rnd    = prod_reg + M_RND;
    assign m_next   = m_rnd[vrrq_pkg::GAIN_FRAC+MMB-1:vrrq_pkg::GAIN_FRAC];
    assign s_rnd    = prod_reg + PAN_RND;
    assign s_val    = s_rnd[vrrq_pkg::PAN_FRAC+MMB-1:vrrq_pkg::PAN_FRAC];

    // Pan fractions, values above one act as one
    assign pan_l = pan_reg[vrrq_pkg::PAN_BITS-1] ? vrrq_pkg::PAN_ONE : pan_reg;
    assign pan_r = vrrq_pkg::PAN_ONE - pan_l;

    // Shared multiplier
    assign mul_p = mul_a * mul_b;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            vrrq_pkg::ST_IDLE:
            begin
                if (accept && (pos_dec_sat < POS_HALF))
                begin
                    state_next = vrrq_pkg::ST_TT;
                end
            end
            vrrq_pkg::ST_TT:  state_next = vrrq_pkg::ST_BT;
            vrrq_pkg::ST_BT:  state_next = vrrq_pkg::ST_CT;
            vrrq_pkg::ST_CT:  state_next = vrrq_pkg::ST_SUM;
            vrrq_pkg::ST_SUM: state_next = vrrq_pkg::ST_Y;
            vrrq_pkg::ST_Y:   state_next = vrrq_pkg::ST_G;
            vrrq_pkg::ST_G:   state_next = vrrq_pkg::ST_M;
            vrrq_pkg::ST_M:
            begin
                state_next = stereo_reg ? vrrq_pkg::ST_PL : vrrq_pkg::ST_EMIT;
            end
            vrrq_pkg::ST_PL:  state_next = vrrq_pkg::ST_PR;
            vrrq_pkg::ST_PR:  state_next = vrrq_pkg::ST_EMIT;
            vrrq_pkg::ST_EMIT:
            begin
                if (emit_go)
                begin
                    state_next = more ? vrrq_pkg::ST_TT : vrrq_pkg::ST_IDLE;
                end
            end
            default: state_next = vrrq_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs: ready and multiplier operands
    always_comb
    begin
        samples_ready = 1'b0;
        mul_en        = 1'b0;
        mul_a         = '0;
        mul_b         = '0;
        case (state_reg)
            vrrq_pkg::ST_IDLE:
            begin
                samples_ready = 1'b1;
            end
            vrrq_pkg::ST_TT:
            begin
                mul_en = 1'b1;
                mul_a  = {{(MB-TW){t_val[TW-1]}}, t_val};
                mul_b  = {{(MB-TW){t_val[TW-1]}}, t_val};
            end
            vrrq_pkg::ST_BT:
            begin
                mul_en = 1'b1;
                mul_a  = {{(MB-DB){b2[DB-1]}}, b2};
                mul_b  = {{(MB-TW){t_val[TW-1]}}, t_val};
            end
            vrrq_pkg::ST_CT:
            begin
                mul_en = 1'b1;
                mul_a  = {{(MB-DB){c2[DB-1]}}, c2};
                mul_b  = {{(MB-TTW){1'b0}}, tt_reg};
            end
            vrrq_pkg::ST_G:
            begin
                mul_en = 1'b1;
                mul_a  = {{(MB-YB){y_reg[YB-1]}}, y_reg};
                mul_b  = {{(MB-vrrq_pkg::GAIN_BITS){1'b0}}, gain_reg};
            end
            vrrq_pkg::ST_PL:
            begin
                mul_en = 1'b1;
                mul_a  = {{(MB-MMB){m_reg[MMB-1]}}, m_reg};
                mul_b  = {{(MB-vrrq_pkg::PAN_BITS){1'b0}}, pan_l};
            end
            vrrq_pkg::ST_PR:
            begin
                mul_en = 1'b1;
                mul_a  = {{(MB-MMB){m_reg[MMB-1]}}, m_reg};
                mul_b  = {{(MB-vrrq_pkg::PAN_BITS){1'b0}}, pan_r};
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= vrrq_pkg::ST_IDLE;
            pos_reg        <= -POS_ONE;
            hist_older_reg <= '0;
            hist_old_reg   <= '0;
            hist_new_reg   <= '0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Shift history and step back on each item
            if (accept)
            begin
                hist_older_reg <= hist_old_reg;
                hist_old_reg   <= hist_new_reg;
                hist_new_reg   <= samples.sample;
                pos_reg        <= pos_dec_sat;
                cnt_reg        <= '0;
            end
            else if (emit_go)
            begin
                pos_reg <= pos_inc_sat;
                cnt_reg <= cnt_reg + 1'b1;
            end

            // Hold the result until taken
            if (emit_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= vrrq_pkg::STEP_RESET;
            gain_reg   <= vrrq_pkg::GAIN_RESET;
            pan_reg    <= vrrq_pkg::PAN_RESET;
            stereo_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                vrrq_pkg::CFG_STEP_RATIO: step_reg   <= cfg.data[vrrq_pkg::RATIO_BITS-1:0];
                vrrq_pkg::CFG_GAIN:       gain_reg   <= cfg.data[vrrq_pkg::GAIN_BITS-1:0];
                vrrq_pkg::CFG_PAN_LEFT:   pan_reg    <= cfg.data[vrrq_pkg::PAN_BITS-1:0];
                vrrq_pkg::CFG_STEREO:     stereo_reg <= cfg.data[0];
                default: ;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= mul_p;
        end
        if (state_reg == vrrq_pkg::ST_BT)
        begin
            tt_reg <= tt_next;
        end
        if (state_reg == vrrq_pkg::ST_CT)
        begin
            acc_reg <= prod_reg[ACCW-1:0];
        end
        if (state_reg == vrrq_pkg::ST_SUM)
        begin
            acc_reg <= acc_next;
        end
        if (state_reg == vrrq_pkg::ST_Y)
        begin
            y_reg <= y_next;
        end
        if (state_reg == vrrq_pkg::ST_M)
        begin
            m_reg <= m_next;
        end
        if (state_reg == vrrq_pkg::ST_PR)
        begin
            pan_l_reg <= vrrq_pkg::sat_sample(s_val);
        end

        // Load the result item
        if (emit_go)
        begin
            left_reg  <= stereo_reg ? pan_l_reg : vrrq_pkg::sat_sample(m_reg);
            right_reg <= stereo_reg ? vrrq_pkg::sat_sample(s_val) : '0;
            last_reg  <= !more;
        end
    end

    assign results.valid     = out_valid_reg;
    assign results.left_out  = left_reg;
    assign results.right_out = right_reg;
    assign results.last      = last_reg;

    // History holds while a burst is in progress
    a_hist_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != vrrq_pkg::ST_IDLE) |=> $stable(hist_new_reg) && $stable(hist_old_reg))
        else $error("history changed during a burst");

    // A result marked last returns the sequencer to idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_go && !more) |=> (state_reg == vrrq_pkg::ST_IDLE))
        else $error("sequencer busy after final result");

    // A continued burst starts only with the position below minus one half
    a_cont_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == vrrq_pkg::ST_TT && $past(state_reg) == vrrq_pkg::ST_EMIT)
        |-> (pos_reg < POS_NHALF))
        else $error("burst continued with position not below minus one half");

    // The burst limit always ends the burst
    a_burst_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_go && cnt_reg == CNT_LAST) |=> (state_reg == vrrq_pkg::ST_IDLE) && last_reg)
        else $error("burst exceeded the result limit");

endmodule

`default_nettype wire

/* bench/testbench.sv */
// Self-checking testbench of the quadratic variable-rate resampler core.
`timescale 1ns / 1ps

module testbench;

    localparam int     FRAC           = vrrq_pkg::FRAC_BITS_DEF;
    localparam int     SB             = vrrq_pkg::SAMPLE_BITS;
    localparam int     DW             = vrrq_pkg::CFG_DATA_BITS;
    localparam int     IW             = vrrq_pkg::CFG_INDEX_BITS;
    localparam longint ONE            = longint'(1) << FRAC;
    localparam longint HALF           = longint'(1) << (FRAC - 1);
    localparam longint POS_MAX        = (longint'(1) << (FRAC + 7)) - 1;
    localparam longint POS_MIN        = -(longint'(1) << (FRAC + 7));
    localparam longint SAMPLE_MAX     = (longint'(1) << (SB - 1)) - 1;
    localparam longint SAMPLE_MIN     = -(longint'(1) << (SB - 1));
    localparam longint PAN_FULL       = longint'(vrrq_pkg::PAN_ONE);
    localparam int     IDLE_SETTLE    = 24;
    localparam int     WATCHDOG_LIMIT = 2000;
    localparam int     MAX_REPORTS    = 10;
    localparam int     PHASES         = 7;
    localparam int     PHASE_ITEMS    = 17;
    localparam logic [DW-1:0] DATA_ALL_ONES = '1;

    typedef struct {
        logic signed [SB-1:0] left;
        logic signed [SB-1:0] right;
        logic                 last;
    } frame_t;

    logic clk = 1'b0;
    logic rst_n;

    vrrq_in_if  samples_if ();
    vrrq_out_if results_if ();
    vrrq_cfg_if cfg_if ();

    variable_rate_resampler_quadratic_core DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_if),
        .results (results_if),
        .cfg     (cfg_if)
    );

    // Predictor state: sample history, read position, register copies
    logic signed [SB-1:0]                tap_oldest;
    logic signed [SB-1:0]                tap_mid;
    logic signed [SB-1:0]                tap_newest;
    longint                              read_pos;
    logic [vrrq_pkg::RATIO_BITS-1:0]     step_reg;
    logic [vrrq_pkg::GAIN_BITS-1:0]      gain_reg;
    logic [vrrq_pkg::PAN_BITS-1:0]       pan_reg;
    logic                                stereo_reg;

    frame_t frames_due[$];
    frame_t want;

    bit stalls_on = 1'b1;
    int ready_hold = 0;
    int idle_cycles = 0;
    int n_items = 0;
    int n_results = 0;
    int n_stereo = 0;
    int n_writes = 0;
    int n_capped = 0;
    int longest_burst = 0;
    int n_mismatch = 0;

    always #2 clk = ~clk;

    function automatic longint clip(input longint x, input longint lo, input longint hi);
        return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    // Round half toward plus infinity, then drop k fraction bits
    function automatic longint round_up_shift(input longint x, input int k);
        return (x + (longint'(1) << (k - 1))) >>> k;
    endfunction

    function automatic logic signed [SB-1:0] to_sample(input longint x);
        longint c;
        c = clip(x, SAMPLE_MIN, SAMPLE_MAX);
        return c[SB-1:0];
    endfunction

    // Quadratic interpolation at the current read position, then gain and pan
    function automatic frame_t interpolate_frame();
        longint y0;
        longint y1;
        longint y2;
        longint b2;
        longint c2;
        longint t;
        longint tt;
        longint y;
        longint m;
        longint p;
        frame_t f;
        y0 = longint'(tap_oldest);
        y1 = longint'(tap_mid);
        y2 = longint'(tap_newest);
        b2 = -3 * y0 + 4 * y1 - y2;
        c2 = y0 - 2 * y1 + y2;
        t  = clip(read_pos + 2 * ONE, -8 * ONE, 8 * ONE);
        tt = round_up_shift(t * t, FRAC);
        y  = y0 + round_up_shift(b2 * t + c2 * tt, FRAC + 1);
        m  = round_up_shift(y * longint'(gain_reg), vrrq_pkg::GAIN_FRAC);
        if (stereo_reg)
        begin
            p = (longint'(pan_reg) > PAN_FULL) ? PAN_FULL : longint'(pan_reg);
            f.left  = to_sample(round_up_shift(m * p, vrrq_pkg::PAN_FRAC));
            f.right = to_sample(round_up_shift(m * (PAN_FULL - p), vrrq_pkg::PAN_FRAC));
        end
        else
        begin
            f.left  = to_sample(m);
            f.right = '0;
        end
        f.last = 1'b0;
        return f;
    endfunction

    // Advance the predictor by one accepted sample and queue its burst
    task automatic take_sample(input logic signed [SB-1:0] s);
        frame_t f;
        longint inc;
        int     n;
        bit     more;
        inc = (longint'(step_reg) << FRAC) >>> vrrq_pkg::RATIO_FRAC;
        tap_oldest = tap_mid;
        tap_mid    = tap_newest;
        tap_newest = s;
        read_pos   = clip(read_pos - ONE, POS_MIN, POS_MAX);
        if (read_pos < HALF)
        begin
            n    = 0;
            more = 1'b1;
            while (more)
            begin
                f        = interpolate_frame();
                n++;
                read_pos = clip(read_pos + inc, POS_MIN, POS_MAX);
                more     = (read_pos < -HALF) && (n < vrrq_pkg::MAX_RESULTS);
                f.last   = !more;
                frames_due.push_back(f);
            end
            if (stereo_reg)
            begin
                n_stereo += n;
            end
            if (n == vrrq_pkg::MAX_RESULTS)
            begin
                n_capped++;
            end
            if (n > longest_burst)
            begin
                longest_burst = n;
            end
        end
    endtask

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!stalls_on || r < 55)
        begin
            return 0;
        end
        if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 96)
        begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    function automatic logic signed [SB-1:0] pick_sample();
        int          r;
        int          v;
        logic [31:0] w;
        r = $urandom_range(0, 15);
        if (r == 0)
        begin
            return 16'sh7FFF;
        end
        if (r == 1)
        begin
            return 16'sh8000;
        end
        if (r < 4)
        begin
            v = $urandom_range(0, 511) - 256;
            return v[SB-1:0];
        end
        w = $urandom;
        return w[SB-1:0];
    endfunction

    // Hold valid through the handshake; lower it only ahead of a gap
    task automatic send_sample(input logic signed [SB-1:0] s);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            samples_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        samples_if.valid  <= 1'b1;
        samples_if.sample <= s;
        @(posedge clk);
        while (!samples_if.ready)
        begin
            @(posedge clk);
        end
        take_sample(s);
        n_items++;
    endtask

    task automatic write_reg(input logic [IW-1:0] idx,
                             input logic [DW-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        @(posedge clk);
        while (!cfg_if.ready)
        begin
            @(posedge clk);
        end
        case (idx)
            vrrq_pkg::CFG_STEP_RATIO: step_reg   = value[vrrq_pkg::RATIO_BITS-1:0];
            vrrq_pkg::CFG_GAIN:       gain_reg   = value[vrrq_pkg::GAIN_BITS-1:0];
            vrrq_pkg::CFG_PAN_LEFT:   pan_reg    = value[vrrq_pkg::PAN_BITS-1:0];
            vrrq_pkg::CFG_STEREO:     stereo_reg = value[0];
            default:                  ;
        endcase
        n_writes++;
    endtask

    task automatic program_regs(input logic [DW-1:0] step,
                                input logic [DW-1:0] gain,
                                input logic [DW-1:0] pan,
                                input logic [DW-1:0] stereo);
        write_reg(vrrq_pkg::CFG_STEP_RATIO, step);
        write_reg(vrrq_pkg::CFG_GAIN, gain);
        write_reg(vrrq_pkg::CFG_PAN_LEFT, pan);
        write_reg(vrrq_pkg::CFG_STEREO, stereo);
        cfg_if.valid <= 1'b0;
    endtask

    // Stop sending, drain every queued result, then let a silent item finish
    task automatic hold_until_drained();
        samples_if.valid <= 1'b0;
        while (frames_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (IDLE_SETTLE) @(posedge clk);
    endtask

    task automatic test_reset_defaults();
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh0000);
        send_sample(-16'sd1);
        send_sample(16'sd1);
        hold_until_drained();
    endtask

    // Full gain on alternating extremes drives the results into saturation
    task automatic test_sample_extremes();
        program_regs(21'd49152, 21'd65535, 21'd32768, 21'd0);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh0000);
        hold_until_drained();
    endtask

    // Hard right, hard left, pan above one, and an odd split
    task automatic test_stereo_pan();
        logic [DW-1:0] pans[4];
        pans[0] = 21'd0;
        pans[1] = 21'(vrrq_pkg::PAN_ONE);
        pans[2] = 21'd131071;
        pans[3] = 21'd12345;
        foreach (pans[i])
        begin
            program_regs(21'd81920, 21'd20000, pans[i], 21'd1);
            send_sample(16'sh7FFF);
            send_sample(16'sh8000);
            hold_until_drained();
        end
    endtask

    // A step below the usual range forces every burst to the per-item cap
    task automatic test_burst_limit();
        program_regs(21'd1024, 21'd4096, 21'd32768, 21'd0);
        send_sample(16'sd1000);
        send_sample(-16'sd2000);
        send_sample(16'sd3000);
        hold_until_drained();
    endtask

    // Writes past the register list must leave the setup untouched
    task automatic test_stray_index();
        logic [IW-1:0] idx;
        for (int i = vrrq_pkg::CFG_STEREO + 1; i < (1 << IW); i++)
        begin
            idx = i[IW-1:0];
            write_reg(idx, DW'($urandom));
        end
        cfg_if.valid <= 1'b0;
        send_sample(pick_sample());
        send_sample(pick_sample());
        hold_until_drained();
    endtask

    // Zero step: position runs down to its floor and t clamps; then recover
    task automatic test_deep_deficit();
        stalls_on = 1'b0;
        program_regs(21'd0, 21'($urandom_range(0, 65535)), 21'd32768, 21'd0);
        repeat (132) send_sample(pick_sample());
        hold_until_drained();
        program_regs(DATA_ALL_ONES, 21'd4096, 21'd32768, 21'd1);
        repeat (4) send_sample(pick_sample());
        hold_until_drained();
        stalls_on = 1'b1;
    endtask

    task automatic test_random_phases();
        logic [DW-1:0] step;
        logic [DW-1:0] gain;
        logic [DW-1:0] pan;
        logic [DW-1:0] stereo;
        int            r;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            r = $urandom_range(0, 9);
            if (r == 0)
            begin
                step = $urandom_range(2048, 8192);
            end
            else if (r == 1)
            begin
                step = $urandom_range(524288, 1048576);
            end
            else
            begin
                step = $urandom_range(16384, 196608);
            end
            gain   = ($urandom_range(0, 1) == 0) ? $urandom_range(2048, 8192)
                                                 : $urandom_range(0, 65535);
            pan    = ($urandom_range(0, 4) == 0) ? $urandom_range(65537, 131071)
                                                 : $urandom_range(0, 65536);
            stereo = $urandom_range(0, 1);
            // Open with the register extremes
            if (phase == 0)
            begin
                step   = 21'd2048;
                gain   = 21'd0;
                pan    = 21'd0;
                stereo = 21'd0;
            end
            else if (phase == 1)
            begin
                step   = 21'd1048576;
                gain   = 21'd65535;
                pan    = 21'(vrrq_pkg::PAN_ONE);
                stereo = 21'd1;
            end
            stalls_on = (phase != 3);
            program_regs(step, gain, pan, stereo);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                send_sample(pick_sample());
                if ((phase == 2 && k == PHASE_ITEMS / 2) || $urandom_range(0, 31) == 0)
                begin
                    hold_until_drained();
                end
            end
            hold_until_drained();
        end
        stalls_on = 1'b1;
    endtask

    // Result-side backpressure
    always @(posedge clk)
    begin
        if (ready_hold > 0)
        begin
            ready_hold--;
            results_if.ready <= 1'b0;
        end
        else
        begin
            if (stalls_on && $urandom_range(0, 3) == 0)
            begin
                ready_hold = draw_gap();
            end
            results_if.ready <= (ready_hold == 0);
        end
    end

    // Compare each accepted result with the oldest queued frame
    always @(posedge clk)
    begin
        if (rst_n && results_if.valid && results_if.ready)
        begin
            n_results++;
            if (frames_due.size() == 0)
            begin
                n_mismatch++;
                if (n_mismatch <= MAX_REPORTS)
                begin
                    $display("result %0d: unexpected item L=%0d R=%0d last=%0b", n_results,
                             results_if.left_out, results_if.right_out, results_if.last);
                end
            end
            else
            begin
                want = frames_due.pop_front();
                if (results_if.left_out !== want.left || results_if.right_out !== want.right
                    || results_if.last !== want.last)
                begin
                    n_mismatch++;
                    if (n_mismatch <= MAX_REPORTS)
                    begin
                        $display({"result %0d: expected L=%0d R=%0d last=%0b,",
                                  " got L=%0d R=%0d last=%0b"},
                                 n_results, want.left, want.right, want.last,
                                 results_if.left_out, results_if.right_out, results_if.last);
                    end
                end
            end
        end
    end

    // Abort when no channel moves an item for too long
    always @(posedge clk)
    begin
        if (!rst_n || (samples_if.valid && samples_if.ready)
            || (results_if.valid && results_if.ready) || (cfg_if.valid && cfg_if.ready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no item moved for %0d cycles, %0d results outstanding",
                         idle_cycles, frames_due.size());
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        samples_if.valid  <= 1'b0;
        samples_if.sample <= '0;
        cfg_if.valid      <= 1'b0;
        cfg_if.index      <= '0;
        cfg_if.data       <= '0;
        rst_n             <= 1'b0;
        tap_oldest = '0;
        tap_mid    = '0;
        tap_newest = '0;
        read_pos   = -ONE;
        step_reg   = vrrq_pkg::STEP_RESET;
        gain_reg   = vrrq_pkg::GAIN_RESET;
        pan_reg    = vrrq_pkg::PAN_RESET;
        stereo_reg = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_sample_extremes();
        test_stereo_pan();
        test_burst_limit();
        test_stray_index();
        test_deep_deficit();
        test_random_phases();

        $display("Sent %0d sample items over %0d register writes;", n_items, n_writes);
        $display("checked %0d results (%0d stereo), longest burst %0d, %0d cut at the cap.",
                 n_results, n_stereo, longest_burst, n_capped);
        if (n_mismatch == 0 && frames_due.size() == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("%0d mismatches, %0d results never seen.", n_mismatch, frames_due.size());
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

/* variable_rate_resampler_quadratic_core.f */
rtl/core/vrrq_pkg.sv
rtl/core/vrrq_if.sv
rtl/core/variable_rate_resampler_quadratic_core.sv
bench/testbench.sv
